FILE: rtl/core/lbcb_pkg.sv
// Shared types and constants for the luminance bin CDF builder.
// No dependencies; every other file in rtl/core imports this package.
package lbcb_pkg;

    localparam int MAX_BINS    = 64;
    localparam int FACE_COUNT  = 6;
    localparam int STORE_DEPTH = FACE_COUNT * MAX_BINS * MAX_BINS;
    localparam int ADDR_W      = 15;

    localparam logic [16:0] W_RED   = 17'd13933;
    localparam logic [16:0] W_GREEN = 17'd46871;
    localparam logic [16:0] W_BLUE  = 17'd4732;
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    localparam logic [6:0]  BINS_RESET   = 7'd16;
    localparam logic [12:0] WIDTH_RESET  = 13'd256;
    localparam logic [12:0] HEIGHT_RESET = 13'd256;

    localparam logic [1:0] FUNC_ACC   = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;
    localparam logic [1:0] FUNC_NOP   = 2'd3;

    localparam logic [1:0] CFG_BINS   = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic [2:0]         face;
        logic [11:0]        pixel_x;
        logic [11:0]        pixel_y;
        logic signed [31:0] red;
        logic signed [31:0] green;
        logic signed [31:0] blue;
        logic [5:0]         bin_row;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  bin_col;
        logic [16:0] cdf_value;
        logic [53:0] row_total;
        logic [62:0] grand_total;
        logic        last;
    } t_out_item;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_ACC_MUL,
        S_ACC_SUM,
        S_ACC_CHK,
        S_DIV_ROW,
        S_DIV_COL,
        S_ACC_RD,
        S_ACC_WR,
        S_RS_RD,
        S_RS_ADD,
        S_CL_RD,
        S_CL_ADD,
        S_CL_DIV,
        S_CL_WAIT,
        S_CL_EMIT
    } t_state;

    typedef struct packed {
        logic cap;
        logic clr_rst;
        logic clr_wr;
        logic mul;
        logic lum;
        logic div_row;
        logic div_col;
        logic div_frac;
        logic row_cap;
        logic col_cap;
        logic rd_acc;
        logic wr_acc;
        logic rd_row;
        logic rsum_zero;
        logic rsum_add;
        logic cum_zero;
        logic cum_add;
        logic c_zero;
        logic c_inc;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] in_func;
        logic       in_face_ok;
        logic       in_row_ok;
        logic       lum_pos;
        logic       div_busy;
        logic       c_last;
        logic       clr_last;
        logic       out_free;
    } t_dp_status;

endpackage

FILE: rtl/core/luminance_bin_cdf_builder_top.sv
// Luminance bin CDF builder: cube-map luminance histogram with per-row CDF readout.
// A pixel (func 0) is accepted, its luminance is formed (multiply, sum, check), then the
// row and column bins are divided in the shared radix-2 divider and the bin store is
// read, added to and written back. A row readout (func 1) first sums the row from the
// bin store one entry at a time, then emits each column after its 17-step fraction
// divide. A clear (func 2), and the pass after reset, sweeps all 24576 store entries one
// per cycle, during which no transaction is accepted; configuration writes are always taken.
// Depends on lbcb_pkg, lbcb_ctrl, lbcb_datapath, lbcb_div.
module luminance_bin_cdf_builder_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lbcb_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lbcb_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [12:0]         i_cfg_data
);
    import lbcb_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    lbcb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    lbcb_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: rtl/core/lbcb_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Integer mode: 18-bit dividend. Fraction mode: floor(num*65536/den), num <= den.
// Depends on lbcb_pkg.
module lbcb_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_frac,
    input  logic [53:0] i_num,
    input  logic [53:0] i_den,
    output logic        o_busy,
    output logic [17:0] o_quot
);
    import lbcb_pkg::*;

    logic        r_busy;
    logic        r_frac;
    logic        r_first;
    logic [4:0]  r_cnt;
    logic [53:0] r_rem;
    logic [53:0] r_den;
    logic [17:0] r_dvd;
    logic [17:0] r_q;

    logic [54:0] w_cand;
    logic [54:0] w_diff;
    logic        w_ge;
    logic [4:0]  w_last;

    always_comb begin
        if (r_first && r_frac) begin
            w_cand = {1'b0, r_rem};
        end else begin
            w_cand = {r_rem, r_dvd[17]};
        end
        w_ge   = (w_cand >= {1'b0, r_den});
        w_diff = w_cand - {1'b0, r_den};
        w_last = r_frac ? 5'd16 : 5'd17;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == w_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_frac  <= i_frac;
            r_first <= 1'b1;
            r_cnt   <= '0;
            r_rem   <= i_frac ? i_num : '0;
            r_den   <= i_den;
            r_dvd   <= i_frac ? '0 : i_num[17:0];
            r_q     <= '0;
        end else if (r_busy) begin
            r_first <= 1'b0;
            r_cnt   <= r_cnt + 5'd1;
            r_rem   <= w_ge ? w_diff[53:0] : w_cand[53:0];
            r_dvd   <= {r_dvd[16:0], 1'b0};
            r_q     <= {r_q[16:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule

FILE: rtl/core/lbcb_datapath.sv
// Datapath: config registers, luminance, bin store, row sums, output register.
// Depends on lbcb_pkg and lbcb_div.
module lbcb_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lbcb_pkg::t_in_item   i_in_data,
    input  logic                 i_cfg_valid,
    input  logic [1:0]           i_cfg_index,
    input  logic [12:0]          i_cfg_data,
    input  logic                 i_out_stall,
    input  lbcb_pkg::t_dp_cmd    i_cmd,
    output lbcb_pkg::t_dp_status o_status,
    output logic                 o_out_valid,
    output lbcb_pkg::t_out_item  o_out_data
);
    import lbcb_pkg::*;

    logic [6:0]  r_n;
    logic [12:0] r_w;
    logic [12:0] r_h;

    t_in_item           r_item;
    logic signed [49:0] r_p_r, r_p_g, r_p_b;
    logic [31:0]        r_lum;
    logic               r_lum_pos;
    logic [5:0]         r_row, r_col, r_c;
    logic [62:0]        r_total;
    logic [53:0]        r_rsum, r_cum;
    logic [ADDR_W-1:0]  r_clr_addr;
    logic [47:0]        r_rdata;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [47:0] mem [0:STORE_DEPTH-1];

    logic               w_rd_en, w_wr_en;
    logic [ADDR_W-1:0]  w_rd_addr, w_wr_addr, w_acc_addr;
    logic [47:0]        w_wr_data;
    logic [48:0]        w_bin_sum;
    logic [63:0]        w_tot_sum;
    logic signed [51:0] w_luma;
    logic [6:0]         w_nm1;
    logic               w_div_start, w_div_frac, w_div_busy;
    logic [53:0]        w_div_num, w_div_den;
    logic [17:0]        w_quot;
    logic [5:0]         w_qclamp;
    logic               w_out_free;
    logic [6:0]         w_cfg_bins;

    assign w_nm1 = r_n - 7'd1;

    // configuration; zero writes are dropped, bin count saturates
    always_comb begin
        if (i_cfg_data[6:0] > 7'(MAX_BINS)) begin
            w_cfg_bins = 7'(MAX_BINS);
        end else begin
            w_cfg_bins = i_cfg_data[6:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= BINS_RESET;
            r_w <= WIDTH_RESET;
            r_h <= HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BINS: begin
                    if (i_cfg_data[6:0] != '0) r_n <= w_cfg_bins;
                end
                CFG_WIDTH: begin
                    if (i_cfg_data != '0) r_w <= i_cfg_data;
                end
                CFG_HEIGHT: begin
                    if (i_cfg_data != '0) r_h <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // luminance: products, then sum and floor shift
    assign w_luma = 52'(r_p_r) + 52'(r_p_g) + 52'(r_p_b);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) r_item <= i_in_data;
        if (i_cmd.mul) begin
            r_p_r <= $signed({1'b0, W_RED})   * r_item.red;
            r_p_g <= $signed({1'b0, W_GREEN}) * r_item.green;
            r_p_b <= $signed({1'b0, W_BLUE})  * r_item.blue;
        end
        if (i_cmd.lum) begin
            r_lum     <= w_luma[47:16];
            r_lum_pos <= !w_luma[51] && (w_luma[50:16] != '0);
        end
    end

    // divider operand select
    always_comb begin
        w_div_start = i_cmd.div_row || i_cmd.div_col || i_cmd.div_frac;
        w_div_frac  = i_cmd.div_frac;
        w_div_num   = '0;
        w_div_den   = '0;
        if (i_cmd.div_row) begin
            w_div_num = 54'(r_item.pixel_y * r_n);
            w_div_den = 54'(r_h);
        end else if (i_cmd.div_col) begin
            w_div_num = 54'(r_item.pixel_x * r_n);
            w_div_den = 54'(r_w);
        end else if (r_rsum != '0) begin
            w_div_num = r_cum;
            w_div_den = r_rsum;
        end else begin
            // empty row: uniform (c+1)/N
            w_div_num = 54'(r_c) + 54'd1;
            w_div_den = 54'(r_n);
        end
    end

    lbcb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_frac  (w_div_frac),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    assign w_qclamp = (w_quot > 18'(w_nm1)) ? w_nm1[5:0] : w_quot[5:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.row_cap) r_row <= w_qclamp;
        if (i_cmd.col_cap) r_col <= w_qclamp;
    end

    // bin store
    assign w_acc_addr = {r_item.face, r_row, r_col};
    assign w_bin_sum  = {1'b0, r_rdata} + 49'(r_lum);
    assign w_tot_sum  = {1'b0, r_total} + 64'(r_lum);

    always_comb begin
        w_rd_en   = i_cmd.rd_acc || i_cmd.rd_row;
        w_rd_addr = i_cmd.rd_acc ? w_acc_addr : {r_item.face, r_item.bin_row, r_c};
        w_wr_en   = i_cmd.clr_wr || i_cmd.wr_acc;
        w_wr_addr = i_cmd.clr_wr ? r_clr_addr : w_acc_addr;
        if (i_cmd.clr_wr) begin
            w_wr_data = '0;
        end else if (w_bin_sum[48]) begin
            w_wr_data = '1;
        end else begin
            w_wr_data = w_bin_sum[47:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) mem[w_wr_addr] <= w_wr_data;
        if (w_rd_en) r_rdata <= mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_total    <= '0;
        end else begin
            if (i_cmd.clr_rst) begin
                r_clr_addr <= '0;
            end else if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (i_cmd.clr_wr) begin
                r_total <= '0;
            end else if (i_cmd.wr_acc) begin
                r_total <= w_tot_sum[63] ? '1 : w_tot_sum[62:0];
            end
        end
    end

    // row readout
    always_ff @(posedge i_clk) begin
        if (i_cmd.rsum_zero) begin
            r_rsum <= '0;
        end else if (i_cmd.rsum_add) begin
            r_rsum <= r_rsum + 54'(r_rdata);
        end
        if (i_cmd.cum_zero) begin
            r_cum <= '0;
        end else if (i_cmd.cum_add) begin
            r_cum <= r_cum + 54'(r_rdata);
        end
        if (i_cmd.c_zero) begin
            r_c <= '0;
        end else if (i_cmd.c_inc) begin
            r_c <= r_c + 6'd1;
        end
    end

    // output register
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.bin_col     <= r_c;
            r_out.cdf_value   <= o_status.c_last ? ONE_Q16 : w_quot[16:0];
            r_out.row_total   <= r_rsum;
            r_out.grand_total <= r_total;
            r_out.last        <= o_status.c_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        o_status.in_func    = i_in_data.func;
        o_status.in_face_ok = (i_in_data.face < 3'(FACE_COUNT));
        o_status.in_row_ok  = ({1'b0, i_in_data.bin_row} < r_n);
        o_status.lum_pos    = r_lum_pos;
        o_status.div_busy   = w_div_busy;
        o_status.c_last     = (r_c == w_nm1[5:0]);
        o_status.clr_last   = (r_clr_addr == ADDR_W'(STORE_DEPTH - 1));
        o_status.out_free   = w_out_free;
    end

endmodule

FILE: rtl/core/lbcb_ctrl.sv
// Control state machine: sequences accumulate, row readout and store clear.
// Depends on lbcb_pkg.
module lbcb_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  lbcb_pkg::t_dp_status i_status,
    output lbcb_pkg::t_dp_cmd    o_cmd
);
    import lbcb_pkg::*;

    t_state r_state, n_state;
    logic   w_accept;

    assign w_accept = i_in_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_status.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    case (i_status.in_func)
                        FUNC_ACC: begin
                            if (i_status.in_face_ok) n_state = S_ACC_MUL;
                        end
                        FUNC_READ: begin
                            if (i_status.in_face_ok && i_status.in_row_ok) n_state = S_RS_RD;
                        end
                        FUNC_CLEAR: n_state = S_CLEAR;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_ACC_MUL: n_state = S_ACC_SUM;
            S_ACC_SUM: n_state = S_ACC_CHK;
            S_ACC_CHK: n_state = i_status.lum_pos ? S_DIV_ROW : S_IDLE;
            S_DIV_ROW: begin
                if (!i_status.div_busy) n_state = S_DIV_COL;
            end
            S_DIV_COL: begin
                if (!i_status.div_busy) n_state = S_ACC_RD;
            end
            S_ACC_RD:  n_state = S_ACC_WR;
            S_ACC_WR:  n_state = S_IDLE;
            S_RS_RD:   n_state = S_RS_ADD;
            S_RS_ADD:  n_state = i_status.c_last ? S_CL_RD : S_RS_RD;
            S_CL_RD:   n_state = S_CL_ADD;
            S_CL_ADD:  n_state = S_CL_DIV;
            S_CL_DIV:  n_state = S_CL_WAIT;
            S_CL_WAIT: begin
                if (!i_status.div_busy) n_state = S_CL_EMIT;
            end
            S_CL_EMIT: begin
                if (i_status.out_free) n_state = i_status.c_last ? S_IDLE : S_CL_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        case (r_state)
            S_CLEAR: o_cmd.clr_wr = 1'b1;
            S_IDLE: begin
                o_cmd.cap       = w_accept;
                o_cmd.clr_rst   = w_accept;
                o_cmd.rsum_zero = w_accept;
                o_cmd.c_zero    = w_accept;
            end
            S_ACC_MUL: o_cmd.mul = 1'b1;
            S_ACC_SUM: o_cmd.lum = 1'b1;
            S_ACC_CHK: o_cmd.div_row = i_status.lum_pos;
            S_DIV_ROW: begin
                o_cmd.row_cap = !i_status.div_busy;
                o_cmd.div_col = !i_status.div_busy;
            end
            S_DIV_COL: o_cmd.col_cap = !i_status.div_busy;
            S_ACC_RD:  o_cmd.rd_acc = 1'b1;
            S_ACC_WR:  o_cmd.wr_acc = 1'b1;
            S_RS_RD:   o_cmd.rd_row = 1'b1;
            S_RS_ADD: begin
                o_cmd.rsum_add = 1'b1;
                o_cmd.c_zero   = i_status.c_last;
                o_cmd.cum_zero = i_status.c_last;
                o_cmd.c_inc    = !i_status.c_last;
            end
            S_CL_RD:   o_cmd.rd_row = 1'b1;
            S_CL_ADD:  o_cmd.cum_add = 1'b1;
            S_CL_DIV:  o_cmd.div_frac = 1'b1;
            S_CL_WAIT: begin
            end
            S_CL_EMIT: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.c_inc    = i_status.out_free && !i_status.c_last;
            end
            default: begin
            end
        endcase
    end

endmodule
